/* hw/rtl/skt_pkg.sv */
// Package: shared types, codes and sizes of the sorted key table.
`default_nettype none
package skt_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int KEY_W        = 32;
  localparam int ATTR_W       = 16;
  localparam int IDX_W        = 8;
  localparam int POS_W        = 9;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_FIND   = 2'd1,
    REQ_READ   = 2'd2,
    REQ_DUMP   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_MISS = 2'd1,
    STS_FULL = 2'd2
  } status_e;

  // what the output register is loaded with
  typedef enum logic [1:0] {
    RES_ENTRY,
    RES_NEW,
    RES_MISS,
    RES_FULL
  } res_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_NEW,
    ST_FIND_RD,
    ST_FIND_CMP,
    ST_READ_OUT,
    ST_DUMP_RD,
    ST_DUMP_OUT,
    ST_EMIT_MISS,
    ST_EMIT_FULL
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic              kind;
    logic [ATTR_W-1:0] attr;
  } entry_t;

  typedef struct packed {
    logic in_ready;
    logic load_req;
    logic rd_en;
    logic rd_prev;
    logic wr_en;
    logic wr_new;
    logic ptr_dec;
    logic ptr_inc;
    logic cnt_inc;
    logic out_load;
    res_e res;
    logic out_last;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    req_e req;
    logic full;
    logic empty;
    logic idx_ok;
    logic ptr_zero;
    logic ptr_end;
    logic ptr_last;
    logic key_le;
    logic key_eq;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

/* hw/rtl/skt_if.sv */
// Interfaces: request and response channels of the sorted key table.
`default_nettype none
interface skt_req_if import skt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [KEY_W-1:0]  key;
  logic              part_kind;
  logic [ATTR_W-1:0] attribute;
  logic [IDX_W-1:0]  index;

  modport source (output valid, req_type, key, part_kind, attribute, index, input ready);
  modport sink   (input valid, req_type, key, part_kind, attribute, index, output ready);
endinterface

interface skt_rsp_if import skt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [POS_W-1:0]  position;
  logic [KEY_W-1:0]  entry_key;
  logic              entry_kind;
  logic [ATTR_W-1:0] entry_attribute;
  logic [POS_W-1:0]  entry_count;
  logic              last;

  modport source (output valid, status, position, entry_key, entry_kind, entry_attribute,
                  entry_count, last, input ready);
  modport sink   (input valid, status, position, entry_key, entry_kind, entry_attribute,
                  entry_count, last, output ready);
endinterface
`default_nettype wire

/* hw/rtl/skt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module skt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output      logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/skt_ctrl.sv */
// Controller: sequences insert, find, read and dump over the entry store.
`default_nettype none
module skt_ctrl import skt_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire sts_t   sts_i,
  output      cmd_t   cmd_o,
  output      state_e state_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q) inside
      ST_IDLE: begin
        if (sts_i.in_valid) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (sts_i.req)
          REQ_INSERT: state_d = sts_i.full ? ST_EMIT_FULL : ST_INS_RD;
          REQ_FIND:   state_d = ST_FIND_RD;
          REQ_READ:   state_d = sts_i.idx_ok ? ST_READ_OUT : ST_EMIT_MISS;
          REQ_DUMP:   state_d = sts_i.empty ? ST_EMIT_MISS : ST_DUMP_RD;
          default:    state_d = ST_IDLE;
        endcase
      end
      ST_INS_RD:   state_d = sts_i.ptr_zero ? ST_INS_NEW : ST_INS_CMP;
      ST_INS_CMP:  state_d = sts_i.key_le ? ST_INS_NEW : ST_INS_RD;
      ST_INS_NEW: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      ST_FIND_RD:  state_d = sts_i.ptr_end ? ST_EMIT_MISS : ST_FIND_CMP;
      ST_FIND_CMP: begin
        if (!sts_i.key_eq) begin
          state_d = ST_FIND_RD;
        end else if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ_OUT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      ST_DUMP_RD:  state_d = ST_DUMP_OUT;
      ST_DUMP_OUT: begin
        if (sts_i.out_free) state_d = sts_i.ptr_last ? ST_IDLE : ST_DUMP_RD;
      end
      ST_EMIT_MISS, ST_EMIT_FULL: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.res = RES_ENTRY;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.load_req = sts_i.in_valid;
      end
      ST_DISPATCH: begin
        cmd_o.rd_en = (sts_i.req == REQ_READ) && sts_i.idx_ok;
      end
      ST_INS_RD: begin
        cmd_o.rd_en   = !sts_i.ptr_zero;
        cmd_o.rd_prev = 1'b1;
      end
      ST_INS_CMP: begin
        cmd_o.wr_en   = !sts_i.key_le;
        cmd_o.ptr_dec = !sts_i.key_le;
      end
      ST_INS_NEW: begin
        cmd_o.wr_en    = sts_i.out_free;
        cmd_o.wr_new   = 1'b1;
        cmd_o.cnt_inc  = sts_i.out_free;
        cmd_o.out_load = sts_i.out_free;
        cmd_o.res      = RES_NEW;
        cmd_o.out_last = 1'b1;
      end
      ST_FIND_RD: begin
        cmd_o.rd_en = !sts_i.ptr_end;
      end
      ST_FIND_CMP: begin
        cmd_o.ptr_inc  = !sts_i.key_eq;
        cmd_o.out_load = sts_i.key_eq && sts_i.out_free;
        cmd_o.out_last = 1'b1;
      end
      ST_READ_OUT: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_last = 1'b1;
      end
      ST_DUMP_RD: begin
        cmd_o.rd_en = 1'b1;
      end
      ST_DUMP_OUT: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.ptr_inc  = sts_i.out_free && !sts_i.ptr_last;
        cmd_o.out_last = sts_i.ptr_last;
      end
      ST_EMIT_MISS: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.res      = RES_MISS;
        cmd_o.out_last = 1'b1;
      end
      ST_EMIT_FULL: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.res      = RES_FULL;
        cmd_o.out_last = 1'b1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/skt_dpath.sv */
// Datapath: request registers, pointer, fill count, entry RAM and output register.
`default_nettype none
module skt_dpath import skt_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  skt_req_if.sink   req_i,
  skt_rsp_if.source rsp_o,
  input  wire cmd_t cmd_i,
  output      sts_t sts_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);

  req_e              req_q;
  logic [KEY_W-1:0]  key_q;
  logic              kind_q;
  logic [ATTR_W-1:0] attr_q;
  logic [IDX_W-1:0]  idx_q;
  logic [PW-1:0]     ptr_q, ptr_d;
  logic [PW-1:0]     cnt_q;
  entry_t            rdata;
  entry_t            wdata;
  logic [AW-1:0]     raddr;

  logic              out_valid_q;
  status_e           out_status_q;
  logic [POS_W-1:0]  out_pos_q;
  entry_t            out_entry_q;
  logic [POS_W-1:0]  out_cnt_q;
  logic              out_last_q;

  assign req_i.ready = cmd_i.in_ready;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q  <= req_e'(req_i.req_type);
      key_q  <= req_i.key;
      kind_q <= req_i.part_kind;
      attr_q <= req_i.attribute;
      idx_q  <= req_i.index;
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.load_req) begin
      case (req_e'(req_i.req_type))
        REQ_INSERT: ptr_d = cnt_q;
        REQ_READ:   ptr_d = PW'(req_i.index);
        default:    ptr_d = '0;
      endcase
    end else if (cmd_i.ptr_dec) begin
      ptr_d = ptr_q - PW'(1);
    end else if (cmd_i.ptr_inc) begin
      ptr_d = ptr_q + PW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      ptr_q <= ptr_d;
      if (cmd_i.cnt_inc) cnt_q <= cnt_q + PW'(1);
    end
  end

  assign raddr = cmd_i.rd_prev ? AW'(ptr_q - PW'(1)) : AW'(ptr_q);
  assign wdata = cmd_i.wr_new ? entry_t'{key: key_q, kind: kind_q, attr: attr_q} : rdata;

  skt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (AW'(ptr_q)),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    sts_o          = '0;
    sts_o.in_valid = req_i.valid;
    sts_o.req      = req_q;
    sts_o.full     = (cnt_q == PW'(CAPACITY));
    sts_o.empty    = (cnt_q == '0);
    sts_o.idx_ok   = (idx_q < IDX_W'(cnt_q));
    sts_o.ptr_zero = (ptr_q == '0);
    sts_o.ptr_end  = (ptr_q == cnt_q);
    sts_o.ptr_last = ((ptr_q + PW'(1)) == cnt_q);
    sts_o.key_le   = (rdata.key <= key_q);
    sts_o.key_eq   = (rdata.key == key_q);
    sts_o.out_free = !out_valid_q || rsp_o.ready;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_last_q <= cmd_i.out_last;
      out_cnt_q  <= (cmd_i.res == RES_NEW) ? POS_W'(cnt_q) + POS_W'(1) : POS_W'(cnt_q);
      case (cmd_i.res)
        RES_ENTRY: begin
          out_status_q <= STS_OK;
          out_pos_q    <= POS_W'(ptr_q);
          out_entry_q  <= rdata;
        end
        RES_NEW: begin
          out_status_q <= STS_OK;
          out_pos_q    <= POS_W'(ptr_q);
          out_entry_q  <= wdata;
        end
        RES_MISS: begin
          out_status_q <= STS_MISS;
          out_pos_q    <= POS_W'(cnt_q);
          out_entry_q  <= '0;
        end
        default: begin
          out_status_q <= STS_FULL;
          out_pos_q    <= POS_W'(cnt_q);
          out_entry_q  <= '0;
        end
      endcase
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.status          = out_status_q;
  assign rsp_o.position        = out_pos_q;
  assign rsp_o.entry_key       = out_entry_q.key;
  assign rsp_o.entry_kind      = out_entry_q.kind;
  assign rsp_o.entry_attribute = out_entry_q.attr;
  assign rsp_o.entry_count     = out_cnt_q;
  assign rsp_o.last            = out_last_q;

endmodule
`default_nettype wire

/* hw/rtl/sorted_key_table.sv */
// Top level of the sorted key table.
// Holds up to CAPACITY entries (key, kind bit, attribute) in ascending key order in one
// single-port-read RAM; equal keys keep arrival order. One request is worked at a time and a
// new request is taken only when the previous one has finished, while its last response may
// still wait in the output register. RAM read data is registered and used in the state that
// follows the read. Each request passes an accept state and a dispatch state; an insert
// then moves each larger entry up one place before it writes the new one, a find compares
// entries from the front, a dump emits every entry in order, and each state that loads a
// response waits while the response side stalls. The entry store has no reset; the fill
// count resets to zero and only positions below it are ever read.
`default_nettype none
module sorted_key_table import skt_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  skt_req_if.sink   req_i,
  skt_rsp_if.source rsp_o
);

  cmd_t   cmd;
  sts_t   sts;
  state_e state;

  skt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .state_o (state)
  );

  skt_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

  // an accepted request is worked before the next one is taken
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready && state == ST_DISPATCH)
    else $error("request taken while busy");

  // entries are never written into a full table
  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_en |-> !sts.full)
    else $error("write into full table");

  // a full report carries the capacity as count
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status == STS_FULL |-> rsp_o.entry_count == POS_W'(CAPACITY))
    else $error("full status with wrong count");

  // error responses always end their request
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status != STS_OK |-> rsp_o.last)
    else $error("error response not marked last");

endmodule
`default_nettype wire

/* tb/sorted_key_table_tb.sv */
// Testbench: sorted key table driven through its request channel, responses scored in order.
`default_nettype none
module sorted_key_table_tb import skt_pkg::*; ();

  localparam int TBL_DEPTH = DEF_CAPACITY;

  typedef struct packed {
    req_e              req;
    logic [KEY_W-1:0]  key;
    logic              kind;
    logic [ATTR_W-1:0] attr;
    logic [IDX_W-1:0]  index;
  } table_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [POS_W-1:0]  position;
    logic [KEY_W-1:0]  key;
    logic              kind;
    logic [ATTR_W-1:0] attr;
    logic [POS_W-1:0]  count;
    logic              last;
  } table_rsp_t;

  // mirror of the table contents plus the responses still owed
  class table_scoreboard;
    logic [KEY_W-1:0]  tbl_key[TBL_DEPTH];
    logic              tbl_kind[TBL_DEPTH];
    logic [ATTR_W-1:0] tbl_attr[TBL_DEPTH];
    int unsigned       fill;
    table_rsp_t        owed_q[$];
    int unsigned       errors;

    function new();
      fill = 0;
      errors = 0;
    endfunction

    function void owe(logic [1:0] st, int unsigned pos, logic [KEY_W-1:0] k, logic kd,
                      logic [ATTR_W-1:0] a, logic lst);
      table_rsp_t r;
      r.status   = st;
      r.position = POS_W'(pos);
      r.key      = k;
      r.kind     = kd;
      r.attr     = a;
      r.count    = POS_W'(fill);
      r.last     = lst;
      owed_q.push_back(r);
    endfunction

    function void note_request(table_req_t r);
      int unsigned p;
      case (r.req)
        REQ_INSERT: begin
          if (fill >= TBL_DEPTH) begin
            owe(STS_FULL, fill, '0, 1'b0, '0, 1'b1);
          end else begin
            p = 0;
            while (p < fill && tbl_key[p] <= r.key) p++;
            for (int unsigned i = fill; i > p; i--) begin
              tbl_key[i]  = tbl_key[i-1];
              tbl_kind[i] = tbl_kind[i-1];
              tbl_attr[i] = tbl_attr[i-1];
            end
            tbl_key[p]  = r.key;
            tbl_kind[p] = r.kind;
            tbl_attr[p] = r.attr;
            fill++;
            owe(STS_OK, p, r.key, r.kind, r.attr, 1'b1);
          end
        end
        REQ_FIND: begin
          p = 0;
          while (p < fill && tbl_key[p] != r.key) p++;
          if (p < fill) owe(STS_OK, p, tbl_key[p], tbl_kind[p], tbl_attr[p], 1'b1);
          else          owe(STS_MISS, fill, '0, 1'b0, '0, 1'b1);
        end
        REQ_READ: begin
          p = 32'(r.index);
          if (p >= fill) owe(STS_MISS, fill, '0, 1'b0, '0, 1'b1);
          else           owe(STS_OK, p, tbl_key[p], tbl_kind[p], tbl_attr[p], 1'b1);
        end
        default: begin
          if (fill == 0) owe(STS_MISS, 0, '0, 1'b0, '0, 1'b1);
          for (p = 0; p < fill; p++)
            owe(STS_OK, p, tbl_key[p], tbl_kind[p], tbl_attr[p], p + 1 == fill);
        end
      endcase
    endfunction

    function void check_response(table_rsp_t got);
      table_rsp_t want;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display({"ERROR: unexpected response st=%0d pos=%0d key=%h kind=%b attr=%h ",
                    "cnt=%0d last=%b"},
                   got.status, got.position, got.key, got.kind, got.attr, got.count, got.last);
        return;
      end
      want = owed_q.pop_front();
      if (got.status !== want.status || got.position !== want.position ||
          got.key !== want.key || got.kind !== want.kind || got.attr !== want.attr ||
          got.count !== want.count || got.last !== want.last) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: exp st=%0d pos=%0d key=%h kind=%b attr=%h cnt=%0d last=%b",
                   want.status, want.position, want.key, want.kind, want.attr, want.count,
                   want.last);
          $display("       got st=%0d pos=%0d key=%h kind=%b attr=%h cnt=%0d last=%b",
                   got.status, got.position, got.key, got.kind, got.attr, got.count, got.last);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  skt_req_if req_if ();
  skt_rsp_if rsp_if ();

  sorted_key_table #(.CAPACITY(TBL_DEPTH)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  table_scoreboard sb = new();
  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int hold_cycles    = 0;
  int send_idle_by_phase[4] = '{0, 74, 0, 10};
  int stall_by_phase[4]     = '{0, 0, 74, 10};

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

  // response side: random stalls, plus a long hold-off when requested
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        rsp_if.ready = 1'b0;
        hold_cycles--;
      end else begin
        rsp_if.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      sb.check_response('{status: rsp_if.status, position: rsp_if.position,
                          key: rsp_if.entry_key, kind: rsp_if.entry_kind,
                          attr: rsp_if.entry_attribute, count: rsp_if.entry_count,
                          last: rsp_if.last});
  end

  function automatic table_req_t mk_req(req_e t, logic [KEY_W-1:0] k, logic kd,
                                        logic [ATTR_W-1:0] a, logic [IDX_W-1:0] ix);
    table_req_t r;
    r.req   = t;
    r.key   = k;
    r.kind  = kd;
    r.attr  = a;
    r.index = ix;
    return r;
  endfunction

  function automatic table_req_t random_request();
    table_req_t  r;
    int unsigned pick;
    int unsigned sel;
    r.key   = $urandom;
    r.kind  = 1'($urandom_range(1));
    r.attr  = ATTR_W'($urandom_range(16'hFFFF));
    r.index = IDX_W'($urandom_range(255));
    pick = $urandom_range(99);
    sel  = $urandom_range(99);
    if (pick < 8) begin
      r.req = REQ_INSERT;
      if (sel < 30 && sb.fill > 0) r.key = sb.tbl_key[$urandom_range(sb.fill - 1)];
      else if (sel < 40)           r.key = $urandom_range(1) ? '1 : '0;
      else if (sel < 55)           r.key = $urandom_range(15);
    end else if (pick < 40) begin
      r.req = REQ_FIND;
      if (sel < 55 && sb.fill > 0)      r.key = sb.tbl_key[$urandom_range(sb.fill - 1)];
      else if (sel < 70 && sb.fill > 0) r.key = sb.tbl_key[$urandom_range(sb.fill - 1)] + 1;
      else if (sel < 80)                r.key = $urandom_range(15);
    end else if (pick < 75) begin
      r.req = REQ_READ;
      if (sel < 70 && sb.fill > 0) r.index = IDX_W'($urandom_range(sb.fill - 1));
    end else begin
      r.req = REQ_DUMP;
    end
    return r;
  endfunction

  task automatic send_request(input table_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid     = 1'b1;
    req_if.req_type  = r.req;
    req_if.key       = r.key;
    req_if.part_kind = r.kind;
    req_if.attribute = r.attr;
    req_if.index     = r.index;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note_request(r);
    @(negedge clk_i);
  endtask

  initial begin
    int waited;
    req_if.valid     = 1'b0;
    req_if.req_type  = REQ_INSERT;
    req_if.key       = '0;
    req_if.part_kind = 1'b0;
    req_if.attribute = '0;
    req_if.index     = '0;
    rst_ni = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty table, extremes, equal keys, misses and out-of-range reads
    send_request(mk_req(REQ_DUMP,   '0, 1'b0, '0, '0));
    send_request(mk_req(REQ_READ,   '0, 1'b0, '0, '0));
    send_request(mk_req(REQ_FIND,   '0, 1'b0, '0, '0));
    send_request(mk_req(REQ_INSERT, '1, 1'b1, '1, '1));
    send_request(mk_req(REQ_INSERT, '0, 1'b0, '0, '0));
    send_request(mk_req(REQ_INSERT, '0, 1'b1, 16'h0001, '0));
    send_request(mk_req(REQ_INSERT, 32'd5, 1'b0, 16'h5555, '0));
    send_request(mk_req(REQ_INSERT, 32'hFFFF_FFFE, 1'b1, 16'hAAAA, '0));
    send_request(mk_req(REQ_FIND,   '0, 1'b0, '0, '0));
    send_request(mk_req(REQ_FIND,   '1, 1'b0, '0, '0));
    send_request(mk_req(REQ_FIND,   32'd7, 1'b0, '0, '0));
    send_request(mk_req(REQ_READ,   '0, 1'b0, '0, 8'd5));
    send_request(mk_req(REQ_READ,   '0, 1'b0, '0, 8'd255));
    send_request(mk_req(REQ_READ,   '0, 1'b0, '0, 8'd4));
    send_request(mk_req(REQ_READ,   '0, 1'b0, '0, 8'd0));
    send_request(mk_req(REQ_DUMP,   '0, 1'b0, '0, '0));

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_idle_by_phase[ph];
      stall_pct     = stall_by_phase[ph];
      for (int n = 0; n < 74; n++) begin
        if (ph == 0 && n == 10) hold_cycles = 300;
        send_request(random_request());
      end
    end

    // top off the table, then hit the full case and the full-table paths
    send_idle_pct = 0;
    stall_pct     = 0;
    while (sb.fill < TBL_DEPTH)
      send_request(mk_req(REQ_INSERT, $urandom, 1'($urandom_range(1)),
                          ATTR_W'($urandom_range(16'hFFFF)), IDX_W'($urandom_range(255))));
    send_request(mk_req(REQ_INSERT, $urandom, 1'b1, '1, '0));
    send_request(mk_req(REQ_DUMP, '0, 1'b0, '0, '0));
    send_request(mk_req(REQ_FIND, sb.tbl_key[TBL_DEPTH-1], 1'b0, '0, '0));
    send_request(mk_req(REQ_READ, '0, 1'b0, '0, IDX_W'(TBL_DEPTH - 1)));
    send_request(mk_req(REQ_READ, '0, 1'b0, '0, IDX_W'(TBL_DEPTH)));
    req_if.valid = 1'b0;

    waited = 0;
    while (sb.owed_q.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (50) @(posedge clk_i);
    if (sb.owed_q.size() != 0) begin
      if (sb.errors < 10) $display("ERROR: %0d responses never arrived", sb.owed_q.size());
      sb.errors += sb.owed_q.size();
    end

    if (sb.errors == 0) $display("DONE: 0 errors");
    else                $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire
